@@ rtl/assert_macros.svh @@
// Assertion helpers for the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal must be low outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/lpht_pkg.sv @@
package lpht_pkg;

  // Slot count; a power of two so that the home slot and the probe wrap are masks.
  localparam int CAPACITY = 256;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REPLACED = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam logic [63:0] FNV_OFFSET = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME  = 64'h00000100000001b3;
  localparam logic [63:0] MIX_ADD    = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2   = 64'h94d049bb133111eb;

  localparam int LOAD_NUM = 3;
  localparam int LOAD_DEN = 4;

endpackage

@@ rtl/linear_probe_hash_table.sv @@
// Flow: the front hashes the key (FNV over the key bytes, then two multiplies) and
// hands the word into the queue; the back end picks it up, reads the home slot's state
// and examines it. Each tombstone passed adds a state read and examine, each live slot also a key compare.
// The front takes a new word only once it has handed the last one to the queue; long
// probe walks or result stalls hold it back only once the two-entry queue is full.
// Reset and clear each run a pass writing every slot empty.
`include "assert_macros.svh"
module linear_probe_hash_table #(
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_key,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_value_out,
  output logic [8:0]  out_entry_count,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  import lpht_pkg::*;
  localparam int KW = 8 * KEY_BYTES;
  localparam int SW = $clog2(CAPACITY);
  localparam int QW = 2 + KW + VALUE_BITS + SW;

  logic [63:0] seed_r;
  logic        fq_valid, q_full, q_empty, q_pop, back_busy;
  logic [1:0]  f_op, b_op;
  logic [KW-1:0] f_key, b_key;
  logic [VALUE_BITS-1:0] f_val, b_val;
  logic [SW-1:0] f_home, b_home;
  logic [QW-1:0] q_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? seed_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) seed_r <= 64'd0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) seed_r <= cfg_pwdata;
  end

  lpht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .seed(seed_r), .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_key(in_key), .in_value(in_value),
    .q_valid(fq_valid), .q_full(q_full), .q_op(f_op), .q_key(f_key), .q_val(f_val),
    .q_home(f_home)
  );

  lpht_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(fq_valid), .wdata({f_op, f_key, f_val, f_home}),
    .full(q_full), .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  assign {b_op, b_key, b_val, b_home} = q_rdata;

  lpht_back #(.KEY_BYTES(KEY_BYTES), .VALUE_BITS(VALUE_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_pop(q_pop), .q_op(b_op),
    .q_key(b_key), .q_val(b_val), .q_home(b_home), .out_valid(out_valid),
    .out_stall(out_stall), .out_status(out_status), .out_value_out(out_value_out),
    .out_entry_count(out_entry_count), .busy(back_busy)
  );

  `ASSERT_IMPL(a_pop_idle, clk, rst_n, q_pop |-> !out_valid, "pop while result pending")
  `ASSERT_NEVER(a_count_max, clk, rst_n, out_entry_count > 9'(CAPACITY), "count overflow")
  `ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid |-> back_busy, "result without busy back end")
endmodule

@@ rtl/lpht_ram.sv @@
module lpht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/lpht_mul64.sv @@
// 64x64 low-half multiply from three 32x32 partial products, taken in turn.
module lpht_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);
  logic [1:0]  cnt_r;
  logic [63:0] a_r, b_r;
  logic [63:0] acc_r;
  logic [31:0] a_sel, b_sel;
  logic [63:0] pp;

  always_comb begin
    a_sel = a_r[31:0];
    b_sel = b_r[31:0];
    unique case (cnt_r)
      2'd1: begin a_sel = a_r[31:0];  b_sel = b_r[63:32]; end
      2'd2: begin a_sel = a_r[63:32]; b_sel = b_r[31:0];  end
      default: begin a_sel = a_r[31:0]; b_sel = b_r[31:0]; end
    endcase
    pp = {32'd0, a_sel} * {32'd0, b_sel};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r   <= a;
        b_r   <= b;
        acc_r <= 64'd0;
        cnt_r <= 2'd3;
      end else if (cnt_r != 2'd0) begin
        // Step 3 takes the full low product, steps 2 and 1 the shifted cross terms.
        if (cnt_r == 2'd3) acc_r <= pp;
        else acc_r <= acc_r + {pp[31:0], 32'd0};
        cnt_r <= cnt_r - 2'd1;
        if (cnt_r == 2'd1) done <= 1'b1;
      end
    end
  end

  always_comb begin
    p = acc_r;
  end
endmodule

@@ rtl/lpht_front.sv @@
// Front end: latches a request, hashes its key to a home slot (a clear skips the
// hash) and hands the classified word on to the queue.
module lpht_front #(
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [63:0]                          seed,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_opcode,
  input  logic [63:0]                          in_key,
  input  logic [63:0]                          in_value,
  output logic                                 q_valid,
  input  logic                                 q_full,
  output logic [1:0]                           q_op,
  output logic [8*KEY_BYTES-1:0]               q_key,
  output logic [VALUE_BITS-1:0]                q_val,
  output logic [$clog2(lpht_pkg::CAPACITY)-1:0] q_home
);
  import lpht_pkg::*;
  localparam int KW = 8 * KEY_BYTES;
  localparam int SW = $clog2(CAPACITY);
  localparam int BW = $clog2(KEY_BYTES + 1);

  typedef enum logic [2:0] {F_IDLE, F_FNV, F_MIX1, F_MIX2, F_OUT} fstate_t;

  fstate_t          state_r;
  logic [1:0]       op_r;
  logic [KW-1:0]    key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [63:0]      h_r;
  logic [BW-1:0]    byte_r;
  logic [SW-1:0]    home_r;
  logic             mul_start_r;
  logic [63:0]      mul_a_r;
  logic [63:0]      mul_b_r;
  logic             mul_done;
  logic [63:0]      mul_p;
  logic [63:0]      fnv_nxt;
  logic [63:0]      z1, z2;
  logic [63:0]      hres;

  lpht_mul64 u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .p(mul_p)
  );

  always_comb begin
    // FNV prime is 2^40 + 0x1b3: shift and a narrow multiply.
    logic [63:0] x;
    x = h_r ^ {56'd0, key_r[8*byte_r[BW-1:0] +: 8]};
    fnv_nxt = (x << 40) + (x * 64'h1b3);
    z1 = (h_r ^ seed) + MIX_ADD;
    z2 = mul_p ^ (mul_p >> 27);
    hres = mul_p ^ (mul_p >> 31);
  end

  assign in_stall = (state_r != F_IDLE);
  assign q_valid  = (state_r == F_OUT);
  assign q_op = op_r;
  assign q_key = key_r;
  assign q_val = val_r;
  assign q_home = home_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      mul_start_r <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      unique case (state_r)
        F_IDLE: if (in_valid) begin
          op_r   <= in_opcode;
          key_r  <= in_key[KW-1:0];
          val_r  <= in_value[VALUE_BITS-1:0];
          h_r    <= FNV_OFFSET;
          byte_r <= '0;
          state_r <= (in_opcode == OP_CLEAR) ? F_OUT : F_FNV;
        end
        F_FNV: begin
          if (byte_r == BW'(KEY_BYTES)) begin
            mul_a_r <= z1 ^ (z1 >> 30);
            mul_b_r <= MIX_MUL1;
            mul_start_r <= 1'b1;
            state_r <= F_MIX1;
          end else begin
            h_r <= fnv_nxt;
            byte_r <= byte_r + 1'b1;
          end
        end
        F_MIX1: if (mul_done) begin
          mul_a_r <= z2;
          mul_b_r <= MIX_MUL2;
          mul_start_r <= 1'b1;
          state_r <= F_MIX2;
        end
        F_MIX2: if (mul_done) begin
          // Capacity is a power of two here, so the modulo is a mask.
          home_r <= hres[SW-1:0];
          state_r <= F_OUT;
        end
        F_OUT: if (!q_full) state_r <= F_IDLE;
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/lpht_queue.sv @@
// Two-entry queue between the hashing front and the probing back.
module lpht_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        mem_r[wp_r] <= wdata;
        wp_r <= ~wp_r;
      end
      if (pop && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push && !full} - {1'b0, pop && !empty};
    end
  end
endmodule

@@ rtl/lpht_back.sv @@
// Back end: walks the slots from the home slot, with a state read and an examine
// for an empty or tombstone slot and a key compare besides for a live one, and
// applies the request. Reset and clear run a pass over the state memory that
// writes every slot empty, one slot per cycle.
module lpht_back #(
  parameter int KEY_BYTES = 8,
  parameter int VALUE_BITS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [1:0]                           q_op,
  input  logic [8*KEY_BYTES-1:0]               q_key,
  input  logic [VALUE_BITS-1:0]                q_val,
  input  logic [$clog2(lpht_pkg::CAPACITY)-1:0] q_home,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_status,
  output logic [63:0]                          out_value_out,
  output logic [8:0]                           out_entry_count,
  output logic                                 busy
);
  import lpht_pkg::*;
  localparam int KW = 8 * KEY_BYTES;
  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    B_INIT, B_IDLE, B_SREAD, B_EXAM, B_DATA, B_CLEAR, B_OUT
  } bstate_t;

  bstate_t          state_r;
  logic [1:0]       op_r;
  logic [KW-1:0]    key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [SW-1:0]    slot_r;
  logic [CW-1:0]    steps_r;
  logic             tomb_seen_r;
  logic [SW-1:0]    tomb_r;
  logic [SW-1:0]    clr_r;
  logic [CW-1:0]    live_r, tombs_r;
  logic             kv_we;
  logic [SW-1:0]    kv_waddr;
  logic [KW-1:0]    key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [SW-1:0]    kv_raddr;
  logic             st_we;
  logic [SW-1:0]    st_waddr;
  logic [1:0]       st_wdata;
  logic [1:0]       st_rd;
  logic [CW+2:0]    load_lhs;

  lpht_ram #(.WIDTH(KW), .DEPTH(CAPACITY)) u_keys (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(key_r),
    .raddr(kv_raddr), .rdata(key_rd)
  );
  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_vals (
    .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(val_r),
    .raddr(kv_raddr), .rdata(val_rd)
  );
  lpht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_states (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(slot_r), .rdata(st_rd)
  );

  assign kv_raddr = slot_r;
  assign q_pop = (state_r == B_IDLE) && !q_empty;
  assign out_valid = (state_r == B_OUT);
  assign busy = (state_r != B_IDLE);
  assign load_lhs = ({3'd0, live_r} + {3'd0, tombs_r} + 1'b1) * (CW+3)'(LOAD_DEN);

  // Slot state writes: the wipe pass, a new or updated entry, or a removal.
  always_comb begin
    st_we = 1'b0;
    st_waddr = slot_r;
    st_wdata = SLOT_LIVE;
    if (state_r == B_INIT || state_r == B_CLEAR) begin
      st_we = 1'b1;
      st_waddr = clr_r;
      st_wdata = SLOT_EMPTY;
    end else if (kv_we) begin
      st_we = 1'b1;
      st_waddr = kv_waddr;
    end else if (state_r == B_DATA && op_r == OP_REMOVE && st_rd == SLOT_LIVE &&
                 key_rd == key_r) begin
      st_we = 1'b1;
      st_wdata = SLOT_TOMB;
    end
  end

  always_comb begin
    kv_we = 1'b0;
    kv_waddr = slot_r;
    if (state_r == B_DATA && op_r == OP_INSERT && st_rd == SLOT_LIVE &&
        key_rd == key_r) begin
      kv_we = 1'b1;
    end else if (state_r == B_EXAM && op_r == OP_INSERT) begin
      if (st_rd == SLOT_EMPTY) begin
        if (tomb_seen_r) begin
          kv_we = 1'b1;
          kv_waddr = tomb_r;
        end else if (!(load_lhs > (CW+3)'(CAPACITY * LOAD_NUM))) begin
          kv_we = 1'b1;
        end
      end else if (steps_r == CW'(CAPACITY) && tomb_seen_r) begin
        kv_we = 1'b1;
        kv_waddr = tomb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_INIT;
      clr_r   <= '0;
      live_r  <= '0;
      tombs_r <= '0;
    end else begin
      unique case (state_r)
        B_INIT: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SW'(CAPACITY - 1)) state_r <= B_IDLE;
        end
        B_IDLE: if (!q_empty) begin
          op_r <= q_op;
          key_r <= q_key;
          val_r <= q_val;
          slot_r <= q_home;
          steps_r <= '0;
          tomb_seen_r <= 1'b0;
          out_value_out <= 64'd0;
          state_r <= (q_op == OP_CLEAR) ? B_CLEAR : B_SREAD;
        end
        B_SREAD: begin
          state_r <= B_EXAM;
        end
        B_EXAM: begin
          if (steps_r == CW'(CAPACITY)) begin
            // Whole table walked without an empty slot.
            if (op_r == OP_INSERT && tomb_seen_r) begin
              out_status <= ST_INSERTED;
              live_r <= live_r + 1'b1;
              tombs_r <= tombs_r - 1'b1;
            end else begin
              out_status <= (op_r == OP_INSERT) ? ST_FULL : ST_NOTFOUND;
            end
            state_r <= B_OUT;
          end else if (st_rd == SLOT_EMPTY) begin
            if (op_r != OP_INSERT) begin
              out_status <= ST_NOTFOUND;
            end else if (tomb_seen_r) begin
              out_status <= ST_INSERTED;
              live_r <= live_r + 1'b1;
              tombs_r <= tombs_r - 1'b1;
            end else if (kv_we) begin
              out_status <= ST_INSERTED;
              live_r <= live_r + 1'b1;
            end else begin
              out_status <= ST_FULL;
            end
            state_r <= B_OUT;
          end else if (st_rd == SLOT_TOMB) begin
            if (!tomb_seen_r) begin
              tomb_seen_r <= 1'b1;
              tomb_r <= slot_r;
            end
            slot_r <= slot_r + 1'b1;
            steps_r <= steps_r + 1'b1;
            state_r <= B_SREAD;
          end else begin
            state_r <= B_DATA;
          end
        end
        B_DATA: begin
          if (key_rd == key_r) begin
            out_value_out <= 64'(val_rd);
            unique case (op_r)
              OP_INSERT: out_status <= ST_REPLACED;
              OP_REMOVE: begin
                out_status <= ST_REMOVED;
                live_r <= live_r - 1'b1;
                tombs_r <= tombs_r + 1'b1;
              end
              default: out_status <= ST_FOUND;
            endcase
            state_r <= B_OUT;
          end else begin
            slot_r <= slot_r + 1'b1;
            steps_r <= steps_r + 1'b1;
            state_r <= B_SREAD;
          end
        end
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == SW'(CAPACITY - 1)) begin
            live_r <= '0;
            tombs_r <= '0;
            out_status <= ST_CLEARED;
            state_r <= B_OUT;
          end
        end
        B_OUT: if (!out_stall) state_r <= B_IDLE;
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_entry_count = 9'(live_r);
endmodule
